// ===== src/pcecn_pkg.sv =====
// ----------------------------------------------------------------------------
// pcecn_pkg
// Shared types and constants of the point cloud extremes / centroid / nearest
// distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pcecn_pkg;

  localparam int COORD_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int SQ_W     = 64;
  localparam int ROOT_W   = 32;
  localparam int SREM_W   = 36;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_DIST = 2'd3;

  // configuration reset values
  localparam logic [31:0] RST_BAND_LOW   = 32'hFFFF_FFF9;
  localparam logic [31:0] RST_BAND_HIGH  = 32'd655360;
  localparam logic [30:0] RST_EDGE_START = 31'd6553600;
  localparam logic [31:0] RST_EMPTY_DIST = 32'd655360;

  // centroid axis select
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       upd;
    logic       sq_z;
    logic       best;
    logic       div_start;
    logic       div_step;
    logic       sqrt_start;
    logic       sqrt_step;
    logic       load;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic step_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/pcecn_if.sv =====
// ----------------------------------------------------------------------------
// pcecn_if
// Valid/ready channels for point words and frame result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcecn_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] px;
  logic [31:0] py;
  logic [31:0] pz;
  logic        frame_end;

  modport source (output valid, px, py, pz, frame_end, input ready);
  modport sink   (input valid, px, py, pz, frame_end, output ready);
endinterface

interface pcecn_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_x;
  logic [31:0] left_y;
  logic [31:0] left_z;
  logic [31:0] right_x;
  logic [31:0] right_y;
  logic [31:0] right_z;
  logic [31:0] mean_x;
  logic [31:0] mean_y;
  logic [31:0] mean_z;
  logic [31:0] nearest_distance;
  logic        no_points;

  modport source (output valid, left_x, left_y, left_z, right_x, right_y, right_z,
                  mean_x, mean_y, mean_z, nearest_distance, no_points, input ready);
  modport sink   (input valid, left_x, left_y, left_z, right_x, right_y, right_z,
                  mean_x, mean_y, mean_z, nearest_distance, no_points, output ready);
endinterface

`default_nettype wire

// ===== src/pcecn_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcecn_ctrl
// Sequencer: per-point update steps, then divide, square root and output load at frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module pcecn_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pcecn_pkg::sts_t sts,
  output pcecn_pkg::cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_UPD  = 9'b000000010,
    S_SQZ  = 9'b000000100,
    S_BEST = 9'b000001000,
    S_DIVS = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_SQS  = 9'b001000000,
    S_SQ   = 9'b010000000,
    S_LOAD = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_SQZ;
      end
      S_SQZ: begin
        cmd.sq_z  = 1'b1;
        state_nxt = S_BEST;
      end
      S_BEST: begin
        cmd.best = 1'b1;
        axis_nxt = pcecn_pkg::AXIS_X;
        state_nxt = sts.last ? S_DIVS : S_IDLE;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) begin
          if (axis_r == pcecn_pkg::AXIS_Z) begin
            state_nxt = S_SQS;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_DIVS;
          end
        end
      end
      S_SQS: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_SQ;
      end
      S_SQ: begin
        cmd.sqrt_step = 1'b1;
        if (sts.step_last) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= pcecn_pkg::AXIS_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/pcecn_dp.sv =====
// ----------------------------------------------------------------------------
// pcecn_dp
// Datapath: config registers, frame accumulators, shared multiplier, serial
// divider and serial square root, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcecn_dp #(
  parameter int MAX_POINTS = 1048576,
  parameter int COORD_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [pcecn_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [pcecn_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  input  wire logic [31:0]                          in_px,
  input  wire logic [31:0]                          in_py,
  input  wire logic [31:0]                          in_pz,
  input  wire logic                                 in_frame_end,
  input  wire pcecn_pkg::cmd_t                      cmd,
  output pcecn_pkg::sts_t                           sts,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [31:0]                               out_left_x,
  output logic [31:0]                               out_left_y,
  output logic [31:0]                               out_left_z,
  output logic [31:0]                               out_right_x,
  output logic [31:0]                               out_right_y,
  output logic [31:0]                               out_right_z,
  output logic [31:0]                               out_mean_x,
  output logic [31:0]                               out_mean_y,
  output logic [31:0]                               out_mean_z,
  output logic [31:0]                               out_nearest_distance,
  output logic                                      out_no_points
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = 32 + CNT_W + 1;
  localparam int STEP_W = $clog2(SUM_W);
  localparam int SH     = 32 - COORD_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  // config
  logic signed [31:0] band_low_r, band_high_r;
  logic [30:0]        edge_start_r;
  logic [31:0]        empty_dist_r;

  // current point
  logic signed [31:0] x_r, y_r, z_r;
  logic               last_r, keep_r;

  // frame state
  logic signed [31:0]      left_x_r, left_y_r, left_z_r;
  logic signed [31:0]      right_x_r, right_y_r, right_z_r;
  logic signed [SUM_W-1:0] sum_r [3];
  logic [CNT_W-1:0]        kcnt_r;
  logic [63:0]             best_r;
  logic                    seen_r;

  logic [63:0] sqx_r, sqz_r;

  // divider / root
  logic [STEP_W-1:0]  step_r;
  logic [SUM_W-1:0]   dvd_r;
  logic [CNT_W:0]     drem_r;
  logic               dneg_r;
  logic [31:0]        mean_r [3];
  logic [63:0]        rad_r;
  logic [pcecn_pkg::SREM_W-1:0] srem_r;
  logic [31:0]        root_r;

  logic               out_valid_r;

  // sign extension of the low COORD_BITS bits
  logic signed [31:0] px_s, py_s, pz_s;
  assign px_s = $signed(in_px << SH) >>> SH;
  assign py_s = $signed(in_py << SH) >>> SH;
  assign pz_s = $signed(in_pz << SH) >>> SH;

  logic signed [31:0] mul_op;
  logic signed [63:0] prod;
  assign mul_op = cmd.sq_z ? z_r : x_r;
  assign prod   = mul_op * mul_op;

  logic        keep_c, qual;
  logic [63:0] sq_sum;
  assign keep_c = !((band_low_r <= y_r) && (y_r <= band_high_r));
  assign qual   = (z_r > 0) || ((z_r == 0) && (y_r < 0));
  assign sq_sum = sqx_r + sqz_r;

  // divider step
  logic [CNT_W:0]     rsh;
  logic               dge;
  logic [SUM_W-1:0]   quo;
  logic [SUM_W-1:0]   quo_s;
  logic signed [SUM_W-1:0] dsrc;
  assign dsrc  = sum_r[cmd.axis];
  assign rsh   = {drem_r[CNT_W-1:0], dvd_r[SUM_W-1]};
  assign dge   = rsh >= {1'b0, kcnt_r};
  assign quo   = {dvd_r[SUM_W-2:0], dge};
  assign quo_s = dneg_r ? (~quo + 1'b1) : quo;

  // root step
  logic [pcecn_pkg::SREM_W-1:0] ssh, trial;
  logic                         sge;
  assign ssh   = {srem_r[pcecn_pkg::SREM_W-3:0], rad_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign sge   = ssh >= trial;

  assign sts.last      = last_r;
  assign sts.step_last = (step_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r   <= pcecn_pkg::RST_BAND_LOW;
      band_high_r  <= pcecn_pkg::RST_BAND_HIGH;
      edge_start_r <= pcecn_pkg::RST_EDGE_START;
      empty_dist_r <= pcecn_pkg::RST_EMPTY_DIST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pcecn_pkg::CFG_BAND_LOW:   band_low_r   <= cfg_wdata;
        pcecn_pkg::CFG_BAND_HIGH:  band_high_r  <= cfg_wdata;
        pcecn_pkg::CFG_EDGE_START: edge_start_r <= cfg_wdata[30:0];
        pcecn_pkg::CFG_EMPTY_DIST: empty_dist_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame state, cleared at reset and after each result
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      left_x_r  <= (!rst_n) ? {1'b0, pcecn_pkg::RST_EDGE_START} : {1'b0, edge_start_r};
      right_x_r <= (!rst_n) ? -{1'b0, pcecn_pkg::RST_EDGE_START} : -{1'b0, edge_start_r};
      left_y_r  <= '0;
      left_z_r  <= '0;
      right_y_r <= '0;
      right_z_r <= '0;
      sum_r[0]  <= '0;
      sum_r[1]  <= '0;
      sum_r[2]  <= '0;
      kcnt_r    <= '0;
      best_r    <= '0;
      seen_r    <= 1'b0;
    end else begin
      if (cmd.upd && keep_c) begin
        if (x_r < left_x_r) begin
          left_x_r <= x_r;
          left_y_r <= y_r;
          left_z_r <= z_r;
        end
        if (x_r > right_x_r) begin
          right_x_r <= x_r;
          right_y_r <= y_r;
          right_z_r <= z_r;
        end
        if (kcnt_r < CNT_MAX) begin
          sum_r[0] <= sum_r[0] + SUM_W'(x_r);
          sum_r[1] <= sum_r[1] + SUM_W'(y_r);
          sum_r[2] <= sum_r[2] + SUM_W'(z_r);
          kcnt_r   <= kcnt_r + 1'b1;
        end
      end
      if (cmd.best && keep_r && qual && (!seen_r || sq_sum < best_r)) begin
        best_r <= sq_sum;
        seen_r <= 1'b1;
      end
    end
  end

  // point registers and arithmetic units
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      x_r    <= px_s;
      y_r    <= py_s;
      z_r    <= pz_s;
      last_r <= in_frame_end;
    end
    if (cmd.upd) begin
      keep_r <= keep_c;
      sqx_r  <= prod;
    end
    if (cmd.sq_z) sqz_r <= prod;

    if (cmd.div_start) begin
      dneg_r <= dsrc[SUM_W-1];
      dvd_r  <= dsrc[SUM_W-1] ? -dsrc : dsrc;
      drem_r <= '0;
      step_r <= STEP_W'(SUM_W - 1);
    end else if (cmd.div_step) begin
      dvd_r  <= quo;
      drem_r <= dge ? (rsh - {1'b0, kcnt_r}) : rsh;
      step_r <= step_r - 1'b1;
      if (step_r == '0) mean_r[cmd.axis] <= (kcnt_r == '0) ? '0 : quo_s[31:0];
    end else if (cmd.sqrt_start) begin
      rad_r  <= best_r;
      srem_r <= '0;
      root_r <= '0;
      step_r <= STEP_W'(pcecn_pkg::ROOT_W - 1);
    end else if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[61:0], 2'b00};
      srem_r <= sge ? (ssh - trial) : ssh;
      root_r <= {root_r[30:0], sge};
      step_r <= step_r - 1'b1;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_left_x           <= left_x_r;
      out_left_y           <= left_y_r;
      out_left_z           <= left_z_r;
      out_right_x          <= right_x_r;
      out_right_y          <= right_y_r;
      out_right_z          <= right_z_r;
      out_mean_x           <= mean_r[0];
      out_mean_y           <= mean_r[1];
      out_mean_z           <= mean_r[2];
      out_nearest_distance <= (root_r == '0) ? empty_dist_r : root_r;
      out_no_points        <= (kcnt_r == '0);
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/point_cloud_extremes_centroid_nearest_unit.sv =====
// ----------------------------------------------------------------------------
// point_cloud_extremes_centroid_nearest_unit
// Frame statistics of a point stream: extremes in x, centroid, nearest x-z
// distance.
// ----------------------------------------------------------------------------
// Input channel in_ch takes one point word (px, py, pz in Q16.16, frame_end).
// Output channel out_ch gives one result word per frame, after the word that
// carries frame_end. cfg_we/cfg_idx/cfg_wdata write the band limits, edge
// start and empty distance; write them only while the unit is idle.
// Each point runs through the steps accept, extreme/sum update with x*x, z*z,
// and the nearest-distance compare. The shared 32x32 multiplier sets this.
// At frame end, the three centroid divisions run one quotient bit per cycle
// (SUM_W = 33 + clog2(MAX_POINTS + 1)), then the square root, then the load
// step.
// The result sits in an output register; the next frame's points are taken
// while it waits. A second result waits in the load step until out_ch frees.
// Reset (synchronous, rst_n low) restores register defaults and clears the
// frame accumulators and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module point_cloud_extremes_centroid_nearest_unit #(
  parameter int MAX_POINTS = 1048576,
  parameter int COORD_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [pcecn_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [pcecn_pkg::CFG_DAT_W-1:0] cfg_wdata,
  pcecn_in_if.sink                             in_ch,
  pcecn_out_if.source                          out_ch
);

  pcecn_pkg::cmd_t cmd;
  pcecn_pkg::sts_t sts;
  logic            in_ready;

  assign in_ch.ready = in_ready;

  pcecn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcecn_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_wdata            (cfg_wdata),
    .in_px                (in_ch.px),
    .in_py                (in_ch.py),
    .in_pz                (in_ch.pz),
    .in_frame_end         (in_ch.frame_end),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_left_x           (out_ch.left_x),
    .out_left_y           (out_ch.left_y),
    .out_left_z           (out_ch.left_z),
    .out_right_x          (out_ch.right_x),
    .out_right_y          (out_ch.right_y),
    .out_right_z          (out_ch.right_z),
    .out_mean_x           (out_ch.mean_x),
    .out_mean_y           (out_ch.mean_y),
    .out_mean_z           (out_ch.mean_z),
    .out_nearest_distance (out_ch.nearest_distance),
    .out_no_points        (out_ch.no_points)
  );

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while previous word in work");

  a_load_needs_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_ch.valid || out_ch.ready))
    else $error("result load over pending output word");

  a_empty_frame_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.no_points |->
      (out_ch.mean_x == '0) && (out_ch.mean_y == '0) && (out_ch.mean_z == '0))
    else $error("empty frame with nonzero centroid");

endmodule

`default_nettype wire
